/* rtl/ilb_pkg.sv */
package ilb_pkg;

	localparam int CAPACITY = 16;
	localparam int WORD_W   = 32;
	localparam int KIND_W   = 3;
	localparam int INDEX_W  = 5;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);
	// common width for index / count compares
	localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ   = 3'd0,
		KIND_WRITE  = 3'd1,
		KIND_APPEND = 3'd2,
		KIND_INSERT = 3'd3,
		KIND_REMOVE = 3'd4,
		KIND_POP    = 3'd5
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_BELOW,
		CELL_FROM_ABOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctrl_t;

endpackage

/* rtl/ilb_cell.sv */
// One list slot: holds, loads the request word, or takes a neighbor's word.
module ilb_cell (
	input  logic                       clk,
	input  ilb_pkg::cell_ctrl_t        ctrl,
	input  logic [ilb_pkg::WORD_W-1:0] load_value,
	input  logic [ilb_pkg::WORD_W-1:0] below,
	input  logic [ilb_pkg::WORD_W-1:0] above,
	output logic [ilb_pkg::WORD_W-1:0] data
);

	logic [ilb_pkg::WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			ilb_pkg::CELL_LOAD:       data_q <= load_value;
			ilb_pkg::CELL_FROM_BELOW: data_q <= below;
			ilb_pkg::CELL_FROM_ABOVE: data_q <= above;
			default:                  data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

/* rtl/indexed_list_buffer_unit.sv */
// Indexed list buffer: an ordered list of up to CAPACITY signed 32-bit words.
// Requests enter on the s_axis channel (kind, index, value); each request
// gives exactly one result on the m_axis channel (word, status, new length).
// Kinds: read, write, append, insert at index, remove at index, pop last.
// Storage is a row of cells, one word each; insert shifts every cell above
// the index up by one and remove shifts them down, all in the same cycle.
// A result is registered and shown in the cycle after its request transfer.
// Throughput: one request per cycle while the result is taken; the request is
// decoded, the read mux over the cells and the cell controls are all settled in that cycle.
// The output register holds the result while m_tready is low; s_tready then
// drops until the result is taken, and a new request is taken in the same
// cycle the pending result leaves.
// Reset (arst_n low) empties the list and the output register; cell words
// are not cleared, only entries below the length are ever read.
// Errors (index out of range, full, empty) change nothing and return zero.
module indexed_list_buffer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [2:0] kind, [7:3] index, [39:8] value
	input  logic [ilb_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] result_value, [33:32] status, [38:34] length, [39] zero
	output logic [ilb_pkg::M_TDATA_W-1:0] m_tdata
);

	// request fields
	logic [ilb_pkg::KIND_W-1:0]  kind;
	logic [ilb_pkg::INDEX_W-1:0] index;
	logic [ilb_pkg::WORD_W-1:0]  value;

	assign kind  = s_tdata[2:0];
	assign index = s_tdata[7:3];
	assign value = s_tdata[39:8];

	logic take;
	logic out_valid_q;

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	// list state
	logic [ilb_pkg::CNT_W-1:0]  count_q;
	logic [ilb_pkg::WORD_W-1:0] cell_data [ilb_pkg::CAPACITY];

	logic [ilb_pkg::CMP_W-1:0]  idx_ext;
	logic [ilb_pkg::CMP_W-1:0]  cnt_ext;
	logic [ilb_pkg::CMP_W-1:0]  rd_addr;
	logic [ilb_pkg::WORD_W-1:0] rd_word;
	logic                       full;

	assign idx_ext = ilb_pkg::CMP_W'(index);
	assign cnt_ext = ilb_pkg::CMP_W'(count_q);
	assign full    = (count_q == ilb_pkg::CNT_W'(ilb_pkg::CAPACITY));

	// pop reads the last entry, everything else reads at the index
	assign rd_addr = (kind == ilb_pkg::KIND_POP) ? (cnt_ext - ilb_pkg::CMP_W'(1)) : idx_ext;
	assign rd_word = cell_data[rd_addr[ilb_pkg::ADDR_W-1:0]];

	// decode
	logic                         do_write, do_append, do_insert, do_remove, do_pop;
	logic [ilb_pkg::WORD_W-1:0]   res_word;
	ilb_pkg::status_t             res_status;
	logic [ilb_pkg::CNT_W-1:0]    count_next;

	always_comb begin
		do_write   = 1'b0;
		do_append  = 1'b0;
		do_insert  = 1'b0;
		do_remove  = 1'b0;
		do_pop     = 1'b0;
		res_word   = '0;
		res_status = ilb_pkg::ST_OK;
		case (ilb_pkg::kind_t'(kind))
			ilb_pkg::KIND_READ: begin
				if (idx_ext < cnt_ext) res_word = rd_word;
				else res_status = ilb_pkg::ST_RANGE;
			end
			ilb_pkg::KIND_WRITE: begin
				if (idx_ext < cnt_ext) do_write = 1'b1;
				else res_status = ilb_pkg::ST_RANGE;
			end
			ilb_pkg::KIND_APPEND: begin
				if (full) res_status = ilb_pkg::ST_FULL;
				else do_append = 1'b1;
			end
			ilb_pkg::KIND_INSERT: begin
				// range check wins over full
				if (idx_ext > cnt_ext) res_status = ilb_pkg::ST_RANGE;
				else if (full) res_status = ilb_pkg::ST_FULL;
				else do_insert = 1'b1;
			end
			ilb_pkg::KIND_REMOVE: begin
				if (idx_ext < cnt_ext) begin
					res_word  = rd_word;
					do_remove = 1'b1;
				end else begin
					res_status = ilb_pkg::ST_RANGE;
				end
			end
			ilb_pkg::KIND_POP: begin
				if (count_q == '0) res_status = ilb_pkg::ST_EMPTY;
				else begin
					res_word = rd_word;
					do_pop   = 1'b1;
				end
			end
			default: ; // unused kinds: no change, status ok
		endcase

		if (do_append || do_insert) count_next = count_q + ilb_pkg::CNT_W'(1);
		else if (do_remove || do_pop) count_next = count_q - ilb_pkg::CNT_W'(1);
		else count_next = count_q;
	end

	// row of cells
	for (genvar i = 0; i < ilb_pkg::CAPACITY; i++) begin : g_cell
		localparam logic [ilb_pkg::CMP_W-1:0] POS = ilb_pkg::CMP_W'(i);

		ilb_pkg::cell_ctrl_t        ctrl;
		logic [ilb_pkg::WORD_W-1:0] below;
		logic [ilb_pkg::WORD_W-1:0] above;

		if (i == 0) begin : g_first
			assign below = cell_data[i];
		end else begin : g_mid_lo
			assign below = cell_data[i-1];
		end

		if (i == ilb_pkg::CAPACITY - 1) begin : g_last
			assign above = cell_data[i];
		end else begin : g_mid_hi
			assign above = cell_data[i+1];
		end

		always_comb begin
			ctrl.op = ilb_pkg::CELL_HOLD;
			if (take) begin
				if (do_write && POS == idx_ext) ctrl.op = ilb_pkg::CELL_LOAD;
				else if (do_append && POS == cnt_ext) ctrl.op = ilb_pkg::CELL_LOAD;
				else if (do_insert && POS == idx_ext) ctrl.op = ilb_pkg::CELL_LOAD;
				else if (do_insert && POS > idx_ext) ctrl.op = ilb_pkg::CELL_FROM_BELOW;
				else if (do_remove && POS >= idx_ext) ctrl.op = ilb_pkg::CELL_FROM_ABOVE;
			end
		end

		ilb_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.load_value (value),
			.below      (below),
			.above      (above),
			.data       (cell_data[i])
		);
	end

	// count and output register
	logic [ilb_pkg::WORD_W-1:0]   out_word_q;
	logic [ilb_pkg::STATUS_W-1:0] out_status_q;
	logic [ilb_pkg::LEN_W-1:0]    out_len_q;
	logic [ilb_pkg::CMP_W-1:0]    cnt_next_ext;

	assign cnt_next_ext = ilb_pkg::CMP_W'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_word_q   <= res_word;
			out_status_q <= res_status;
			out_len_q    <= cnt_next_ext[ilb_pkg::LEN_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_len_q, out_status_q, out_word_q};

endmodule
